[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NPS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define NPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NPS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define NPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/nps_pkg.sv]
// Types, codes and constants of the nearest point search block.
package nps_pkg;

    localparam int MAX_RECORDS_DEF = 1024;
    localparam int COORD_W = 16;
    localparam int COLOUR_W = 8;
    localparam int IDX_W = 10;
    localparam int DIST_W = 33;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] size;
        logic [COLOUR_W-1:0] colour;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    // Tag that travels with each record through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

[rtl/nps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nps_dist.sv]
// Shared squared-distance unit: subtract, square and sum over three stages.
module nps_dist #(
    parameter int AW = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nps_pkg::tag_t                       in_tag,
    input  logic [AW-1:0]                       in_idx,
    input  nps_pkg::record_t                    in_rec,
    input  logic signed [nps_pkg::COORD_W-1:0]  qx,
    input  logic signed [nps_pkg::COORD_W-1:0]  qy,
    output nps_pkg::tag_t                       out_tag,
    output logic [AW-1:0]                       out_idx,
    output nps_pkg::record_t                    out_rec,
    output logic [nps_pkg::DIST_W-1:0]          out_dist
);

    localparam int DW = nps_pkg::COORD_W + 1;
    localparam int SQ_W = 2 * nps_pkg::COORD_W;

    nps_pkg::tag_t tag1_reg, tag2_reg, tag3_reg;
    logic [AW-1:0] idx1_reg, idx2_reg, idx3_reg;
    nps_pkg::record_t rec1_reg, rec2_reg, rec3_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [DW-1:0] dx_next, dy_next;
    logic signed [2*DW-1:0] prod_x, prod_y;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [nps_pkg::DIST_W-1:0] dist_reg, dist_next;

    assign dx_next = DW'(in_rec.x) - DW'(qx);
    assign dy_next = DW'(in_rec.y) - DW'(qy);

    // A 17-bit difference squared stays below 2^32, so the low bits are exact.
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    assign dist_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= in_idx;
        rec1_reg <= in_rec;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        idx2_reg <= idx1_reg;
        rec2_reg <= rec1_reg;
        sqx_reg <= prod_x[SQ_W-1:0];
        sqy_reg <= prod_y[SQ_W-1:0];
        idx3_reg <= idx2_reg;
        rec3_reg <= rec2_reg;
        dist_reg <= dist_next;
    end

    assign out_tag = tag3_reg;
    assign out_idx = idx3_reg;
    assign out_rec = rec3_reg;
    assign out_dist = dist_reg;

endmodule

[rtl/nearest_point_search.sv]
// Top level of the nearest point search block: sequencer, store and result.
//
// A word is taken at a rising edge with start high and busy low. The operation
// field selects clear, load or query; an unused code is answered with status
// ok and changes nothing. Every word gives exactly one result word, shown for
// a single cycle with done high; the receiver cannot hold it off.
// Clear, load, an unused code and a query on an empty store answer in the
// cycle after the word is taken, and busy stays low, so such words may follow
// each other in every cycle.
// A query reads the stored records one per cycle from position 0 upward and
// feeds them through one shared squared-distance unit (subtract, square,
// sum); each distance is then compared against the best so far. Busy is
// high until the cycle of the result; the next word may be taken at the
// edge that ends the result cycle. Each record passes the memory read
// register and the distance unit before its compare, and the result is
// registered after the last compare.
// Equal distances keep the record at the lower position.
// Reset empties the store (record count zero) and clears busy and done;
// memory contents are not cleared and need no clearing pass.
module nearest_point_search #(
    parameter int MAX_RECORDS = nps_pkg::MAX_RECORDS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           operation,
    input  logic signed [nps_pkg::COORD_W-1:0]   point_x,
    input  logic signed [nps_pkg::COORD_W-1:0]   point_y,
    input  logic signed [nps_pkg::COORD_W-1:0]   hex_size,
    input  logic [nps_pkg::COLOUR_W-1:0]         hex_colour,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [nps_pkg::COORD_W-1:0]   best_x,
    output logic signed [nps_pkg::COORD_W-1:0]   best_y,
    output logic signed [nps_pkg::COORD_W-1:0]   best_size,
    output logic [nps_pkg::COLOUR_W-1:0]         best_colour,
    output logic [nps_pkg::IDX_W-1:0]            best_index
);

`include "assert_macros.svh"

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int IW = nps_pkg::IDX_W;

    nps_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic signed [nps_pkg::COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic found_reg, found_next;
    logic [nps_pkg::DIST_W-1:0] best_d_reg, best_d_next;
    nps_pkg::record_t best_rec_reg, best_rec_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [AW+IW-1:0] best_idx_wide;

    nps_pkg::tag_t rd_tag_reg, rd_tag_next;
    logic [AW-1:0] rd_idx_reg;

    logic done_reg, done_next;
    logic [1:0] status_reg, status_next;
    nps_pkg::record_t res_rec_reg, res_rec_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;

    logic accept;
    logic last_issue;
    logic ram_we, ram_re;
    nps_pkg::record_t wr_rec;
    logic [nps_pkg::RECORD_W-1:0] ram_rdata;
    nps_pkg::record_t rd_rec;

    nps_pkg::tag_t d_tag;
    logic [AW-1:0] d_idx;
    nps_pkg::record_t d_rec;
    logic [nps_pkg::DIST_W-1:0] d_dist;

    assign accept = start && (state_reg == nps_pkg::S_IDLE);
    assign last_issue = (state_reg == nps_pkg::S_SCAN)
                        && ((CW'(addr_reg) + CW'(1)) == count_reg);

    assign wr_rec.x = point_x;
    assign wr_rec.y = point_y;
    assign wr_rec.size = hex_size;
    assign wr_rec.colour = hex_colour;

    nps_ram #(
        .WIDTH(nps_pkg::RECORD_W),
        .DEPTH(MAX_RECORDS),
        .AW(AW)
    ) u_store (
        .clk(clk),
        .we(ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(wr_rec),
        .re(ram_re),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    assign rd_rec = nps_pkg::record_t'(ram_rdata);

    nps_dist #(
        .AW(AW)
    ) u_dist (
        .clk(clk),
        .rst_n(rst_n),
        .in_tag(rd_tag_reg),
        .in_idx(rd_idx_reg),
        .in_rec(rd_rec),
        .qx(qx_reg),
        .qy(qy_reg),
        .out_tag(d_tag),
        .out_idx(d_idx),
        .out_rec(d_rec),
        .out_dist(d_dist)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nps_pkg::S_IDLE:
            begin
                if (accept && (operation == nps_pkg::OP_QUERY) && (count_reg != '0))
                begin
                    state_next = nps_pkg::S_SCAN;
                end
            end
            nps_pkg::S_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = nps_pkg::S_DRAIN;
                end
            end
            nps_pkg::S_DRAIN:
            begin
                if (d_tag.valid && d_tag.last)
                begin
                    state_next = nps_pkg::S_DONE;
                end
            end
            nps_pkg::S_DONE:
            begin
                state_next = nps_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nps_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control and result selection.
    always_comb
    begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        count_next = count_reg;
        addr_next = addr_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        found_next = found_reg;
        best_d_next = best_d_reg;
        best_rec_next = best_rec_reg;
        best_idx_next = best_idx_reg;
        done_next = 1'b0;
        status_next = nps_pkg::STAT_OK;
        res_rec_next = '0;
        res_idx_next = '0;

        unique case (state_reg)
            nps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        nps_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next = 1'b1;
                        end
                        nps_pkg::OP_LOAD:
                        begin
                            if (count_reg < CW'(MAX_RECORDS))
                            begin
                                ram_we = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = nps_pkg::STAT_FULL;
                            end
                            done_next = 1'b1;
                        end
                        nps_pkg::OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = nps_pkg::STAT_EMPTY;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                qx_next = point_x;
                                qy_next = point_y;
                                addr_next = '0;
                                found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            nps_pkg::S_SCAN:
            begin
                ram_re = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            nps_pkg::S_DRAIN:
            begin
            end
            nps_pkg::S_DONE:
            begin
                done_next = 1'b1;
                res_rec_next = best_rec_reg;
                res_idx_next = best_idx_wide[IW-1:0];
            end
            default:
            begin
            end
        endcase

        // Strict less-than keeps the earliest record on a tie.
        if (d_tag.valid && (!found_reg || (d_dist < best_d_reg)))
        begin
            found_next = 1'b1;
            best_d_next = d_dist;
            best_rec_next = d_rec;
            best_idx_next = d_idx;
        end
    end

    assign best_idx_wide = (AW + IW)'(best_idx_reg);

    assign rd_tag_next.valid = ram_re;
    assign rd_tag_next.last = last_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nps_pkg::S_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
            rd_tag_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            rd_tag_reg <= rd_tag_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        best_d_reg <= best_d_next;
        best_rec_reg <= best_rec_next;
        best_idx_reg <= best_idx_next;
        rd_idx_reg <= addr_reg;
        status_reg <= status_next;
        res_rec_reg <= res_rec_next;
        res_idx_reg <= res_idx_next;
    end

    assign busy = (state_reg != nps_pkg::S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
    assign best_x = res_rec_reg.x;
    assign best_y = res_rec_reg.y;
    assign best_size = res_rec_reg.size;
    assign best_colour = res_rec_reg.colour;
    assign best_index = res_idx_reg;

    `NPS_ASSERT_CLK(a_accept_answers, clk, rst_n, (start && !busy) |=> (done || busy), "accepted word neither answered nor in progress")
    `NPS_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(MAX_RECORDS), "record count beyond store depth")
    `NPS_ASSERT_CLK(a_scan_in_range, clk, rst_n, (state_reg == nps_pkg::S_SCAN) |-> (CW'(addr_reg) < count_reg), "scan address beyond stored records")
    `NPS_ASSERT_CLK(a_empty_status, clk, rst_n, (done && (status == nps_pkg::STAT_EMPTY)) |-> (count_reg == '0), "empty status with records stored")

endmodule
